FILE: design/dsg_pkg.sv
`default_nettype none

package dsg_pkg;

    // Tone datapath sizes
    localparam int PHASE_BITS     = 24;
    localparam int SINE_ADDR_BITS = 10;
    localparam int LENGTH_BITS    = 16;

    // Fixed field widths of the channels
    localparam int STEP_IN_BITS = 24;
    localparam int LEN_IN_BITS  = 16;
    localparam int VOL_BITS     = 16;
    localparam int SAMPLE_BITS  = 16;

    // Quarter-wave sine table
    localparam int SINE_BITS     = 15;
    localparam int ROM_ADDR_BITS = SINE_ADDR_BITS + 1;
    localparam int SINE_QTR      = 1 << SINE_ADDR_BITS;
    localparam int ROM_DEPTH     = SINE_QTR + 1;
    localparam int SINE_MAX      = 32767;

    // Reciprocal divider and shared multiplier
    localparam int RECIP_BITS   = 32;
    localparam int DIV_CNT_BITS = $clog2(RECIP_BITS);
    localparam int MUL_BITS     = 32;
    localparam int PROD_BITS    = 2 * MUL_BITS;
    localparam int ENV_BITS     = 16;
    localparam int ENV_SHIFT    = 16;
    localparam int MAG_SHIFT    = 30;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic                   is_start;
        logic [PHASE_BITS-1:0]  step;
        logic [LENGTH_BITS-1:0] len;
        logic [VOL_BITS-1:0]    vol;
    } cmd_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DIV,
        B_LOAD,
        B_ENV,
        B_MAG,
        B_MAG_WAIT,
        B_VOL,
        B_VOL_WAIT,
        B_DONE
    } back_state_t;

    // One table entry: round(32767 * sin(pi/2 * k / Q)) by a Q30 Taylor series
    function automatic logic [SINE_BITS-1:0] sine_entry(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        int                 n;
        x    = (HALF_PI_Q30 * 64'(k)) >> SINE_ADDR_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (n = 1; n <= 7; n++)
        begin
            term = (term * x2) >> 30;
            unique case (n)
                1: term = term / 64'd6;
                2: term = term / 64'd20;
                3: term = term / 64'd42;
                4: term = term / 64'd72;
                5: term = term / 64'd110;
                6: term = term / 64'd156;
                default: term = term / 64'd210;
            endcase
            if ((n & 1) != 0)
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            sum = 64'sd0;
        v = (unsigned'(sum) * 64'd32767 + 64'd536870912) >> 30;
        if (v > 64'd32767)
            v = 64'd32767;
        return v[SINE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/dsg_req_if.sv
`default_nettype none

interface dsg_req_if;
    logic                               valid;
    logic                               ready;
    logic [0:0]                         req_type;
    logic [dsg_pkg::STEP_IN_BITS-1:0]   phase_step;
    logic [dsg_pkg::LEN_IN_BITS-1:0]    tone_length;
    logic [dsg_pkg::VOL_BITS-1:0]       volume;

    modport source (output valid, req_type, phase_step, tone_length, volume, input ready);
    modport sink   (input valid, req_type, phase_step, tone_length, volume, output ready);
endinterface

`default_nettype wire

FILE: design/dsg_res_if.sv
`default_nettype none

interface dsg_res_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [dsg_pkg::SAMPLE_BITS-1:0] sample;
    logic                                   active;
    logic                                   last;

    modport source (output valid, sample, active, last, input ready);
    modport sink   (input valid, sample, active, last, output ready);
endinterface

`default_nettype wire

FILE: design/decaying_sine_tone_generator_top.sv
`default_nettype none

// Channel  Dir  Payload                                     Handshake
// req      in   req_type, phase_step, tone_length, volume   valid/ready
// res      out  sample, active, last                        valid/ready
//
// A tick that plays a sample goes in the back end through a registered sine
// table read and three passes through one shared 32x32 multiplier.
// A start runs the one-bit-a-cycle divider for 2^31/length;
// a zero-length start or an idle tick skips the divider and the multiplier.
// Reset clears all tone state; the block comes up idle with no clearing pass.
// A two-entry queue and the result register keep input and output stalls apart.
module decaying_sine_tone_generator_top (
    input  wire logic clk,
    input  wire logic rst_n,
    dsg_req_if.sink   req,
    dsg_res_if.source res
);

    logic          push_valid;
    logic          push_ready;
    dsg_pkg::cmd_t push_cmd;
    logic          pop_valid;
    logic          pop_ready;
    dsg_pkg::cmd_t pop_cmd;

    dsg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    dsg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    dsg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .res       (res)
    );

endmodule

`default_nettype wire

FILE: design/dsg_sine_rom.sv
`default_nettype none

module dsg_sine_rom (
    input  wire logic                              clk,
    input  wire logic [dsg_pkg::ROM_ADDR_BITS-1:0] addr,
    output logic      [dsg_pkg::SINE_BITS-1:0]     data
);

    logic [dsg_pkg::SINE_BITS-1:0] rom_w [dsg_pkg::ROM_DEPTH];
    logic [dsg_pkg::SINE_BITS-1:0] data_reg;

    // Build the quarter wave at elaboration
    for (genvar k = 0; k < dsg_pkg::ROM_DEPTH; k++)
    begin : g_entry
        assign rom_w[k] = dsg_pkg::sine_entry(k);
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        data_reg <= rom_w[addr];
    end

    assign data = data_reg;

endmodule

`default_nettype wire

FILE: design/dsg_front.sv
`default_nettype none

module dsg_front (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dsg_req_if.sink    req,
    output logic       push_valid,
    input  wire logic  push_ready,
    output dsg_pkg::cmd_t push_cmd
);

    logic          hold_valid_reg;
    dsg_pkg::cmd_t hold_cmd_reg;
    logic          take;

    assign req.ready = !hold_valid_reg || push_ready;
    assign take      = req.valid && req.ready;

    // Hold flag: set on a new item, drop once the queue takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (take)
            hold_valid_reg <= 1'b1;
        else if (push_ready)
            hold_valid_reg <= 1'b0;
    end

    // Classify the item and mask the fields to the datapath widths
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_cmd_reg.is_start <= req.req_type[0];
            hold_cmd_reg.step     <= (dsg_pkg::PHASE_BITS)'(req.phase_step);
            hold_cmd_reg.len      <= (dsg_pkg::LENGTH_BITS)'(req.tone_length);
            hold_cmd_reg.vol      <= req.volume;
        end
    end

    assign push_valid = hold_valid_reg;
    assign push_cmd   = hold_cmd_reg;

endmodule

`default_nettype wire

FILE: design/dsg_queue.sv
`default_nettype none

module dsg_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire dsg_pkg::cmd_t  push_cmd,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output dsg_pkg::cmd_t       pop_cmd
);

    dsg_pkg::cmd_t                 mem_reg [dsg_pkg::QUEUE_DEPTH];
    logic [dsg_pkg::QPTR_BITS-1:0] wr_ptr_reg;
    logic [dsg_pkg::QPTR_BITS-1:0] rd_ptr_reg;
    logic [dsg_pkg::QPTR_BITS:0]   count_reg;
    logic                          push;
    logic                          pop;

    assign push_ready = count_reg != (dsg_pkg::QPTR_BITS + 1)'(dsg_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_cmd    = mem_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

FILE: design/dsg_back.sv
`default_nettype none

module dsg_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           pop_valid,
    output logic                pop_ready,
    input  wire dsg_pkg::cmd_t  pop_cmd,
    dsg_res_if.source           res
);

    dsg_pkg::back_state_t state_reg;
    dsg_pkg::back_state_t state_next;

    // Tone state
    logic [dsg_pkg::PHASE_BITS-1:0]  phase_acc_reg;
    logic [dsg_pkg::PHASE_BITS-1:0]  step_reg;
    logic [dsg_pkg::LENGTH_BITS-1:0] idx_reg;
    logic [dsg_pkg::LENGTH_BITS-1:0] len_reg;
    logic [dsg_pkg::VOL_BITS-1:0]    vol_reg;
    logic [dsg_pkg::RECIP_BITS-1:0]  recip_reg;
    logic                            playing_reg;

    // Work registers
    dsg_pkg::cmd_t                    cmd_reg;
    logic                             tone_reg;
    logic [dsg_pkg::LENGTH_BITS-1:0]  rem_reg;
    logic [dsg_pkg::RECIP_BITS-1:0]   quot_reg;
    logic [dsg_pkg::DIV_CNT_BITS-1:0] cnt_reg;
    logic [dsg_pkg::MUL_BITS-1:0]     mul_a_reg;
    logic [dsg_pkg::MUL_BITS-1:0]     mul_b_reg;
    logic [dsg_pkg::PROD_BITS-1:0]    prod_reg;
    logic [dsg_pkg::SINE_BITS-1:0]    mag_s_reg;
    logic                             neg_reg;

    // Result register
    logic                                   out_valid_reg;
    logic signed [dsg_pkg::SAMPLE_BITS-1:0] out_sample_reg;
    logic                                   out_active_reg;
    logic                                   out_last_reg;

    logic                                  tone_due;
    logic                                  slot_free;
    logic                                  emit;
    logic [dsg_pkg::SINE_ADDR_BITS+1:0]    paddr;
    logic [dsg_pkg::ROM_ADDR_BITS-1:0]     rom_addr;
    logic [dsg_pkg::SINE_BITS-1:0]         rom_data;
    logic [dsg_pkg::LENGTH_BITS:0]         trial;
    logic                                  trial_ge;
    logic                                  div_bit;
    logic [dsg_pkg::PROD_BITS-1:0]         prod;
    logic [dsg_pkg::PROD_BITS-dsg_pkg::MAG_SHIFT-1:0] mag_full;
    logic [dsg_pkg::SINE_BITS-1:0]         mag;
    logic [dsg_pkg::SAMPLE_BITS-1:0]       word;
    logic                                  fin;

    assign tone_due  = playing_reg && (idx_reg < len_reg);
    assign slot_free = !out_valid_reg || res.ready;
    assign emit      = (state_reg == dsg_pkg::B_DONE) && slot_free;

    // Quarter-wave address from the top phase bits
    assign paddr    = phase_acc_reg[dsg_pkg::PHASE_BITS-1 -: dsg_pkg::SINE_ADDR_BITS+2];
    assign rom_addr = paddr[dsg_pkg::SINE_ADDR_BITS]
                    ? (dsg_pkg::ROM_ADDR_BITS)'(dsg_pkg::SINE_QTR)
                      - {1'b0, paddr[dsg_pkg::SINE_ADDR_BITS-1:0]}
                    : {1'b0, paddr[dsg_pkg::SINE_ADDR_BITS-1:0]};

    dsg_sine_rom u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    // Restoring divider step for 2^31 / length of the pending start
    assign div_bit  = cnt_reg == (dsg_pkg::DIV_CNT_BITS)'(dsg_pkg::RECIP_BITS - 1);
    assign trial    = {rem_reg, div_bit};
    assign trial_ge = trial >= {1'b0, cmd_reg.len};

    // Shared multiplier
    assign prod = mul_a_reg * mul_b_reg;

    // Saturate magnitude and apply sign
    assign mag_full = prod_reg[dsg_pkg::PROD_BITS-1:dsg_pkg::MAG_SHIFT];
    assign mag      = (mag_full > (dsg_pkg::PROD_BITS - dsg_pkg::MAG_SHIFT)'(dsg_pkg::SINE_MAX))
                    ? (dsg_pkg::SINE_BITS)'(dsg_pkg::SINE_MAX)
                    : mag_full[dsg_pkg::SINE_BITS-1:0];
    assign word     = neg_reg ? -{1'b0, mag} : {1'b0, mag};
    assign fin      = ({1'b0, idx_reg} + 1'b1) == {1'b0, len_reg};

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dsg_pkg::B_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and queue pop
    always_comb
    begin
        state_next = state_reg;
        pop_ready  = 1'b0;
        unique case (state_reg)
            dsg_pkg::B_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    if (pop_cmd.is_start)
                        state_next = (pop_cmd.len != '0) ? dsg_pkg::B_DIV : dsg_pkg::B_DONE;
                    else if (tone_due)
                        state_next = dsg_pkg::B_LOAD;
                    else
                        state_next = dsg_pkg::B_DONE;
                end
            end
            dsg_pkg::B_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = dsg_pkg::B_DONE;
            end
            dsg_pkg::B_LOAD:     state_next = dsg_pkg::B_ENV;
            dsg_pkg::B_ENV:      state_next = dsg_pkg::B_MAG;
            dsg_pkg::B_MAG:      state_next = dsg_pkg::B_MAG_WAIT;
            dsg_pkg::B_MAG_WAIT: state_next = dsg_pkg::B_VOL;
            dsg_pkg::B_VOL:      state_next = dsg_pkg::B_VOL_WAIT;
            dsg_pkg::B_VOL_WAIT: state_next = dsg_pkg::B_DONE;
            dsg_pkg::B_DONE:
            begin
                if (slot_free)
                    state_next = dsg_pkg::B_IDLE;
            end
            default:             state_next = dsg_pkg::B_IDLE;
        endcase
    end

    // Tone state: load on start, advance on a played sample, drop after the last sample or on an idle tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg <= '0;
            step_reg      <= '0;
            idx_reg       <= '0;
            len_reg       <= '0;
            vol_reg       <= '0;
            recip_reg     <= '0;
            playing_reg   <= 1'b0;
        end
        else if (emit)
        begin
            if (tone_reg)
            begin
                phase_acc_reg <= phase_acc_reg + step_reg;
                idx_reg       <= idx_reg + 1'b1;
                if (fin)
                    playing_reg <= 1'b0;
            end
            else if (cmd_reg.is_start)
            begin
                phase_acc_reg <= '0;
                step_reg      <= cmd_reg.step;
                idx_reg       <= '0;
                len_reg       <= cmd_reg.len;
                vol_reg       <= cmd_reg.vol;
                recip_reg     <= quot_reg;
                playing_reg   <= cmd_reg.len != '0;
            end
            else
            begin
                playing_reg <= 1'b0;
            end
        end
    end

    // Work datapath: divider, multiplier operands and product
    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        unique case (state_reg)
            dsg_pkg::B_IDLE:
            begin
                if (pop_valid)
                begin
                    cmd_reg  <= pop_cmd;
                    tone_reg <= !pop_cmd.is_start && tone_due;
                    rem_reg  <= '0;
                    quot_reg <= '0;
                    cnt_reg  <= (dsg_pkg::DIV_CNT_BITS)'(dsg_pkg::RECIP_BITS - 1);
                end
            end
            dsg_pkg::B_DIV:
            begin
                rem_reg  <= trial_ge ? (dsg_pkg::LENGTH_BITS)'(trial - {1'b0, cmd_reg.len})
                                     : trial[dsg_pkg::LENGTH_BITS-1:0];
                quot_reg <= {quot_reg[dsg_pkg::RECIP_BITS-2:0], trial_ge};
                cnt_reg  <= cnt_reg - 1'b1;
            end
            dsg_pkg::B_LOAD:
            begin
                mul_a_reg <= (dsg_pkg::MUL_BITS)'(len_reg - idx_reg);
                mul_b_reg <= (dsg_pkg::MUL_BITS)'(recip_reg);
            end
            dsg_pkg::B_ENV:
            begin
                mag_s_reg <= rom_data;
                neg_reg   <= paddr[dsg_pkg::SINE_ADDR_BITS+1];
            end
            dsg_pkg::B_MAG:
            begin
                mul_a_reg <= (dsg_pkg::MUL_BITS)'(prod_reg[dsg_pkg::ENV_SHIFT +: dsg_pkg::ENV_BITS]);
                mul_b_reg <= (dsg_pkg::MUL_BITS)'(mag_s_reg);
            end
            dsg_pkg::B_VOL:
            begin
                mul_a_reg <= prod_reg[dsg_pkg::MUL_BITS-1:0];
                mul_b_reg <= (dsg_pkg::MUL_BITS)'(vol_reg);
            end
            default:
            begin
            end
        endcase
    end

    // Result valid: set on emit, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            if (tone_reg)
            begin
                out_sample_reg <= signed'(word);
                out_active_reg <= 1'b1;
                out_last_reg   <= fin;
            end
            else
            begin
                out_sample_reg <= '0;
                out_active_reg <= 1'b0;
                out_last_reg   <= 1'b0;
            end
        end
    end

    assign res.valid  = out_valid_reg;
    assign res.sample = out_sample_reg;
    assign res.active = out_active_reg;
    assign res.last   = out_last_reg;

endmodule

`default_nettype wire
